// ----- src/i2cts_pkg.sv -----
package i2cts_pkg;

    // Transaction state, encoded as it appears on the new_state field.
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_ACTIVE     = 3'd1,
        ST_RX         = 3'd2,
        ST_RX_DISCARD = 3'd3,
        ST_TX_WAIT    = 3'd4,
        ST_TX         = 3'd5,
        ST_TX_PAD     = 3'd6
    } t_txn_state;

    // Event codes carried by the action field.
    typedef enum logic [3:0] {
        ACT_SHUTDOWN    = 4'd0,
        ACT_START       = 4'd1,
        ACT_RX_FULL     = 4'd2,
        ACT_RX_DISCARD  = 4'd3,
        ACT_READ_REQ    = 4'd4,
        ACT_TX_TIMEOUT  = 4'd5,
        ACT_TX_ABORT    = 4'd6,
        ACT_TX_DEPLETED = 4'd7,
        ACT_RESTART     = 4'd8,
        ACT_STOP        = 4'd9,
        ACT_DISCARD_REQ = 4'd10,
        ACT_PAD_NOW     = 4'd11,
        ACT_PAD_PREEMPT = 4'd12,
        ACT_READ_RETRY  = 4'd13
    } t_action;

    // Notification codes carried by the notify_code field.
    typedef enum logic [2:0] {
        NTF_NONE        = 3'd0,
        NTF_SHUTDOWN    = 3'd1,
        NTF_RX_DISCARD  = 3'd2,
        NTF_TX_ABORT    = 3'd3,
        NTF_TX_DEPLETED = 3'd4,
        NTF_REARM_START = 3'd5
    } t_notify;

    // One result word.
    typedef struct packed {
        logic [2:0] new_state;
        logic       deliver_rx_data;
        logic       rx_pending;
        logic       rx_complete;
        logic       tx_complete;
        logic       drop_rx_queue;
        logic       ask_read_handler;
        logic       load_tx;
        logic       send_pad;
        logic [2:0] notify_code;
        logic       accepted;
        logic       retry_read;
    } t_result;

endpackage

// ----- src/i2cts_evt_if.sv -----
interface i2cts_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic       has_tx_data;

    modport source (output valid, output action, output has_tx_data, input ready);
    modport sink   (input valid, input action, input has_tx_data, output ready);
endinterface

// ----- src/i2cts_rsp_if.sv -----
interface i2cts_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] new_state;
    logic       deliver_rx_data;
    logic       rx_pending;
    logic       rx_complete;
    logic       tx_complete;
    logic       drop_rx_queue;
    logic       ask_read_handler;
    logic       load_tx;
    logic       send_pad;
    logic [2:0] notify_code;
    logic       accepted;
    logic       retry_read;

    modport source (
        output valid, output new_state, output deliver_rx_data, output rx_pending,
        output rx_complete, output tx_complete, output drop_rx_queue,
        output ask_read_handler, output load_tx, output send_pad,
        output notify_code, output accepted, output retry_read,
        input ready
    );
    modport sink (
        input valid, input new_state, input deliver_rx_data, input rx_pending,
        input rx_complete, input tx_complete, input drop_rx_queue,
        input ask_read_handler, input load_tx, input send_pad,
        input notify_code, input accepted, input retry_read,
        output ready
    );
endinterface

// ----- src/i2cts_step.sv -----
module i2cts_step (
    input  i2cts_pkg::t_txn_state i_state,
    input  logic [3:0]            i_action,
    input  logic                  i_has_tx_data,
    input  logic                  i_depleted_en,
    output i2cts_pkg::t_txn_state o_next_state,
    output i2cts_pkg::t_result    o_result
);
    import i2cts_pkg::*;

    t_txn_state next_state;
    t_result    res;

    always_comb begin
        next_state = i_state;
        res        = '0;
        case (t_action'(i_action))
            ACT_SHUTDOWN: begin
                res.notify_code = NTF_SHUTDOWN;
                next_state      = ST_IDLE;
            end
            ACT_START: begin
                res.notify_code = NTF_REARM_START;
                next_state      = ST_ACTIVE;
            end
            ACT_RX_FULL: begin
                if (i_state == ST_ACTIVE) begin
                    next_state     = ST_RX;
                    res.rx_pending = 1'b1;
                end else if (i_state == ST_RX) begin
                    res.deliver_rx_data = 1'b1;
                    res.rx_pending      = 1'b1;
                end else if (i_state inside {ST_TX, ST_TX_PAD, ST_TX_WAIT}) begin
                    // The transmit has to finish first.
                    res.drop_rx_queue = 1'b0;
                end else begin
                    res.drop_rx_queue = 1'b1;
                end
            end
            ACT_RX_DISCARD: begin
                res.notify_code = NTF_RX_DISCARD;
                next_state      = ST_RX_DISCARD;
            end
            ACT_READ_REQ: begin
                if (i_state inside {ST_ACTIVE, ST_TX_WAIT, ST_TX}) begin
                    res.ask_read_handler = 1'b1;
                    res.load_tx          = i_has_tx_data;
                    next_state           = i_has_tx_data ? ST_TX : ST_TX_WAIT;
                end else if (!(i_state inside {ST_RX, ST_RX_DISCARD})) begin
                    res.send_pad = 1'b1;
                end
            end
            ACT_TX_TIMEOUT: begin
                next_state = ST_TX_PAD;
            end
            ACT_TX_ABORT: begin
                res.notify_code = NTF_TX_ABORT;
                next_state      = ST_TX;
            end
            ACT_TX_DEPLETED: begin
                if (i_depleted_en) begin
                    res.notify_code = NTF_TX_DEPLETED;
                end
            end
            ACT_RESTART, ACT_STOP: begin
                // Close out whatever transfer was in flight.
                if (i_state == ST_RX) begin
                    res.deliver_rx_data = 1'b1;
                    res.rx_complete     = 1'b1;
                end else if (i_state inside {ST_TX, ST_TX_PAD}) begin
                    res.tx_complete = 1'b1;
                end
                if (t_action'(i_action) == ACT_RESTART) begin
                    res.notify_code = NTF_REARM_START;
                    next_state      = ST_ACTIVE;
                end else begin
                    next_state = ST_IDLE;
                end
            end
            ACT_DISCARD_REQ: begin
                if (i_state == ST_RX) begin
                    next_state   = ST_RX_DISCARD;
                    res.accepted = 1'b1;
                end
            end
            ACT_PAD_NOW, ACT_PAD_PREEMPT: begin
                if (i_state == ST_TX) begin
                    next_state   = ST_TX_PAD;
                    res.accepted = 1'b1;
                end
            end
            ACT_READ_RETRY: begin
                if (i_state == ST_TX_WAIT) begin
                    res.accepted   = 1'b1;
                    res.retry_read = 1'b1;
                end
            end
            default: begin
                res.accepted = 1'b0;
            end
        endcase
        res.new_state = next_state;
    end

    assign o_next_state = next_state;
    assign o_result     = res;

endmodule

// ----- src/i2c_target_transaction_sequencer.sv -----
// Transaction sequencer for the target side of an I2C interface.
//
// Channels: i_evt carries one bus or firmware event per word (action code
// plus the has_tx_data flag of a read request). o_rsp returns exactly one
// result word per event: the state after the event and the action strobes.
// i_cfg_wr_en/i_cfg_wr_data write the depleted-handler-present bit, which
// decides whether a transmit-depleted event raises a notification.
//
// The result of an accepted event is registered: into the result register,
// or into the skid register while that is stalled. One event is taken per
// cycle while the receiver keeps up; the state update is the only loop.
//
// A two-word output stage (result register plus skid register) decouples
// the channels. When the receiver stalls, one more event is still taken
// into the skid register, after which i_evt.ready drops until o_rsp moves.
//
// Reset (synchronous, active low) returns the state to idle, sets the
// depleted-handler-present bit and empties the output stage.
module i2c_target_transaction_sequencer (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    i2cts_evt_if.sink   i_evt,
    i2cts_rsp_if.source o_rsp
);
    import i2cts_pkg::*;

    t_txn_state r_state;
    t_txn_state step_next_state;
    logic       r_depleted_en;

    t_result    step_result;
    t_result    r_out;
    t_result    r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;

    logic       evt_accept;
    logic       rsp_pop;

    // The skid register is the only thing that can block new events.
    assign i_evt.ready = !r_skid_valid;
    assign evt_accept  = i_evt.valid && !r_skid_valid;
    assign rsp_pop     = r_out_valid && o_rsp.ready;

    // All event decoding is one pass of combinational logic on the
    // current state and the incoming word.
    i2cts_step u_step (
        .i_state       (r_state),
        .i_action      (i_evt.action),
        .i_has_tx_data (i_evt.has_tx_data),
        .i_depleted_en (r_depleted_en),
        .o_next_state  (step_next_state),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_depleted_en <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_depleted_en <= i_cfg_wr_data;
            end
            if (evt_accept) begin
                r_state <= step_next_state;
            end
        end
    end

    // Output stage: the result register feeds o_rsp; the skid register
    // catches a word that arrives while the result register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (rsp_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (evt_accept) begin
            if (!r_out_valid || rsp_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (rsp_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (rsp_pop) begin
                r_out <= r_skid;
            end
        end else if (evt_accept) begin
            if (!r_out_valid || rsp_pop) begin
                r_out <= step_result;
            end else begin
                r_skid <= step_result;
            end
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.new_state        = r_out.new_state;
    assign o_rsp.deliver_rx_data  = r_out.deliver_rx_data;
    assign o_rsp.rx_pending       = r_out.rx_pending;
    assign o_rsp.rx_complete      = r_out.rx_complete;
    assign o_rsp.tx_complete      = r_out.tx_complete;
    assign o_rsp.drop_rx_queue    = r_out.drop_rx_queue;
    assign o_rsp.ask_read_handler = r_out.ask_read_handler;
    assign o_rsp.load_tx          = r_out.load_tx;
    assign o_rsp.send_pad         = r_out.send_pad;
    assign o_rsp.notify_code      = r_out.notify_code;
    assign o_rsp.accepted         = r_out.accepted;
    assign o_rsp.retry_read       = r_out.retry_read;

`ifndef SYNTHESIS
    // A word in the skid register always sits behind a full result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the result register is empty");

    // A shutdown always lands the block in idle.
    a_shutdown_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_accept && i_evt.action == ACT_SHUTDOWN) |=> r_state == ST_IDLE)
        else $error("shutdown did not return the state to idle");

    // A stalled full result register with a new event must fill the skid.
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_accept && r_out_valid && !o_rsp.ready) |=> r_skid_valid)
        else $error("event accepted under stall was not captured");

    // The state reported with a fresh result is the state the block now holds.
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_accept && (!r_out_valid || rsp_pop)) |=> r_out.new_state == r_state)
        else $error("reported state differs from the held state");
`endif

endmodule

// ----- sim/i2c_target_transaction_sequencer_tb.sv -----
module i2c_target_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cts_pkg::*;

    // The run stops here no matter what. The slowest correct run stays far below it.
    localparam int CYCLE_LIMIT    = 200000;
    // Extra edges allowed for the output stage to settle once the queue is empty.
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 40;
    localparam int RANDOM_PER_SET = 165;

    // One row of the directed walk. If the result is obvious at a glance, it is
    // typed in (pinned). Every other row is checked against the state predictor.
    typedef struct {
        logic [3:0] action;
        logic       has_tx_data;
        bit         pinned;
        t_result    result;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    i2cts_evt_if evt ();
    i2cts_rsp_if rsp ();

    i2c_target_transaction_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_evt         (evt),
        .o_rsp         (rsp)
    );

    // This is the testbench's own view of the transaction state and of the
    // depleted-handler bit. Both follow the block's behavior word by word.
    t_txn_state model_state;
    logic       model_depleted_en;

    t_result    expected_results[$];
    t_stim_row  directed_rows[$];

    // The monitor reads these at the edge where the current word is accepted.
    bit         pin_next;
    t_result    pin_value;

    int sender_idle_pct;
    int receiver_stall_pct;
    int words_sent;
    int results_checked;
    int error_count;
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // This function works out the result word for one event and moves the
    // model state forward. Any strobe that the event does not name stays at zero.
    function automatic t_result next_txn_result(input logic [3:0] act, input logic has_data);
        t_result    r;
        t_txn_state cur;
        cur = model_state;
        r   = '0;
        case (act)
            ACT_SHUTDOWN: begin
                r.notify_code = NTF_SHUTDOWN;
                model_state   = ST_IDLE;
            end
            ACT_START: begin
                r.notify_code = NTF_REARM_START;
                model_state   = ST_ACTIVE;
            end
            ACT_RX_FULL: begin
                // Data that arrives while a transmit is in progress waits until
                // it ends. In idle or while discarding, the data is dropped.
                if (cur == ST_ACTIVE) begin
                    model_state  = ST_RX;
                    r.rx_pending = 1'b1;
                end else if (cur == ST_RX) begin
                    r.deliver_rx_data = 1'b1;
                    r.rx_pending      = 1'b1;
                end else if (!(cur inside {ST_TX, ST_TX_PAD, ST_TX_WAIT})) begin
                    r.drop_rx_queue = 1'b1;
                end
            end
            ACT_RX_DISCARD: begin
                r.notify_code = NTF_RX_DISCARD;
                model_state   = ST_RX_DISCARD;
            end
            ACT_READ_REQ: begin
                if (cur inside {ST_ACTIVE, ST_TX_WAIT, ST_TX}) begin
                    r.ask_read_handler = 1'b1;
                    if (has_data) begin
                        r.load_tx   = 1'b1;
                        model_state = ST_TX;
                    end else begin
                        model_state = ST_TX_WAIT;
                    end
                end else if (!(cur inside {ST_RX, ST_RX_DISCARD})) begin
                    r.send_pad = 1'b1;
                end
            end
            ACT_TX_TIMEOUT: begin
                model_state = ST_TX_PAD;
            end
            ACT_TX_ABORT: begin
                r.notify_code = NTF_TX_ABORT;
                model_state   = ST_TX;
            end
            ACT_TX_DEPLETED: begin
                if (model_depleted_en) begin
                    r.notify_code = NTF_TX_DEPLETED;
                end
            end
            ACT_RESTART, ACT_STOP: begin
                // Closing a transaction finishes whatever was in flight.
                if (cur == ST_RX) begin
                    r.deliver_rx_data = 1'b1;
                    r.rx_complete     = 1'b1;
                end else if (cur inside {ST_TX, ST_TX_PAD}) begin
                    r.tx_complete = 1'b1;
                end
                if (act == ACT_RESTART) begin
                    r.notify_code = NTF_REARM_START;
                    model_state   = ST_ACTIVE;
                end else begin
                    model_state = ST_IDLE;
                end
            end
            ACT_DISCARD_REQ: begin
                if (cur == ST_RX) begin
                    model_state = ST_RX_DISCARD;
                    r.accepted  = 1'b1;
                end
            end
            ACT_PAD_NOW, ACT_PAD_PREEMPT: begin
                if (cur == ST_TX) begin
                    model_state = ST_TX_PAD;
                    r.accepted  = 1'b1;
                end
            end
            ACT_READ_RETRY: begin
                if (cur == ST_TX_WAIT) begin
                    r.accepted   = 1'b1;
                    r.retry_read = 1'b1;
                end
            end
            default: begin
                // The two unused codes leave everything as it is.
            end
        endcase
        r.new_state = model_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] seen);
        if (want !== seen) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            end else if (error_count == MAX_REPORTS + 1) begin
                $display("%0t: further mismatches are counted but not shown", $time);
            end
        end
    endtask

    task automatic check_result(input t_result want, input t_result seen);
        check_field("new_state", want.new_state, seen.new_state);
        check_field("deliver_rx_data", 3'(want.deliver_rx_data), 3'(seen.deliver_rx_data));
        check_field("rx_pending", 3'(want.rx_pending), 3'(seen.rx_pending));
        check_field("rx_complete", 3'(want.rx_complete), 3'(seen.rx_complete));
        check_field("tx_complete", 3'(want.tx_complete), 3'(seen.tx_complete));
        check_field("drop_rx_queue", 3'(want.drop_rx_queue), 3'(seen.drop_rx_queue));
        check_field("ask_read_handler", 3'(want.ask_read_handler),
                    3'(seen.ask_read_handler));
        check_field("load_tx", 3'(want.load_tx), 3'(seen.load_tx));
        check_field("send_pad", 3'(want.send_pad), 3'(seen.send_pad));
        check_field("notify_code", want.notify_code, seen.notify_code);
        check_field("accepted", 3'(want.accepted), 3'(seen.accepted));
        check_field("retry_read", 3'(want.retry_read), 3'(seen.retry_read));
    endtask

    // This block samples both channels at the rising edge. The result side is handled
    // first. Because the block registers its results, a word that is accepted
    // at this edge cannot be the one whose result is leaving at the same edge.
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (rsp.valid && rsp.ready) begin
                seen = {rsp.new_state, rsp.deliver_rx_data, rsp.rx_pending, rsp.rx_complete,
                        rsp.tx_complete, rsp.drop_rx_queue, rsp.ask_read_handler,
                        rsp.load_tx, rsp.send_pad, rsp.notify_code, rsp.accepted,
                        rsp.retry_read};
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result word with nothing expected, expected none, actual %h",
                             $time, seen);
                end else begin
                    want = expected_results.pop_front();
                    check_result(want, seen);
                    results_checked++;
                end
            end
            if (evt.valid && evt.ready) begin
                // The predictor runs even for pinned rows, so the model state stays in step.
                want = next_txn_result(evt.action, evt.has_tx_data);
                if (pin_next) begin
                    want = pin_value;
                end
                expected_results.push_back(want);
            end
        end
    end

    // The receiver stalls at random. The chance of a stall depends on the phase of the run.
    always @(negedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // If the run hangs, the limit is reached, and this block ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding",
                     $time, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // This task offers one event word and holds it until the block accepts it.
    // Before the word goes out, the sender can idle for a random number of cycles.
    task automatic send_word(input logic [3:0] act, input logic has_data,
                             input bit pinned = 1'b0, input t_result res = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            evt.valid <= 1'b0;
            @(negedge i_clk);
        end
        pin_next  = pinned;
        pin_value = res;
        evt.valid       <= 1'b1;
        evt.action      <= act;
        evt.has_tx_data <= has_data;
        do @(posedge i_clk); while (!evt.ready);
        words_sent++;
    endtask

    // The sender goes quiet until every expected result word has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        evt.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The depleted-handler bit is written only while the block is drained.
    task automatic write_depleted_en(input logic value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_wr_en       <= 1'b1;
        i_cfg_wr_data     <= value;
        model_depleted_en  = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic add_row(input logic [3:0] act, input logic has_data, input bit pinned = 1'b0,
                           input t_txn_state st = ST_IDLE, input t_notify nt = NTF_NONE);
        t_stim_row row;
        row.action        = act;
        row.has_tx_data   = has_data;
        row.pinned        = pinned;
        row.result        = '0;
        row.result.new_state   = st;
        row.result.notify_code = nt;
        directed_rows.push_back(row);
    endtask

    // This is the directed walk. It starts from reset with the depleted bit at 1. It visits
    // every state, uses every action code (including the two unused ones), and covers
    // firmware requests that arrive in the wrong state.
    task automatic load_directed_table();
        add_row(ACT_STOP, 1'b0, 1'b1, ST_IDLE, NTF_NONE);
        add_row(ACT_RX_FULL, 1'b1);                       // idle: drop the queue
        add_row(ACT_READ_REQ, 1'b0);                      // idle: pad byte
        add_row(ACT_TX_DEPLETED, 1'b1, 1'b1, ST_IDLE, NTF_TX_DEPLETED);
        add_row(ACT_START, 1'b0, 1'b1, ST_ACTIVE, NTF_REARM_START);
        add_row(ACT_RX_FULL, 1'b0);
        add_row(ACT_RX_FULL, 1'b1);
        add_row(ACT_READ_REQ, 1'b1);                      // receiving: ignored
        add_row(ACT_PAD_NOW, 1'b0, 1'b1, ST_RX, NTF_NONE);
        add_row(ACT_READ_RETRY, 1'b1, 1'b1, ST_RX, NTF_NONE);
        add_row(ACT_RESTART, 1'b0);                       // ends a receive
        add_row(ACT_RX_FULL, 1'b0);
        add_row(ACT_DISCARD_REQ, 1'b1);
        add_row(ACT_RX_FULL, 1'b0);                       // discarding: drop
        add_row(ACT_RESTART, 1'b1);
        add_row(ACT_READ_REQ, 1'b0);
        add_row(ACT_READ_RETRY, 1'b0);
        add_row(ACT_READ_REQ, 1'b1);
        add_row(ACT_PAD_PREEMPT, 1'b0);
        add_row(ACT_READ_REQ, 1'b0);                      // padding: pad byte
        add_row(ACT_TX_ABORT, 1'b1);
        add_row(ACT_PAD_NOW, 1'b1);
        add_row(ACT_TX_TIMEOUT, 1'b0);
        add_row(ACT_RESTART, 1'b0);                       // ends a transmit
        add_row(ACT_RX_DISCARD, 1'b1);
        add_row(4'd14, 1'b1);
        add_row(4'd15, 1'b0, 1'b1, ST_RX_DISCARD, NTF_NONE);
        add_row(ACT_SHUTDOWN, 1'b1, 1'b1, ST_IDLE, NTF_SHUTDOWN);
    endtask

    // This task sends one random bus transaction. Most of them are well formed: a start,
    // then a write or a read body, then a restart, stop or shutdown. The rest are single
    // noise words that can carry any code.
    task automatic send_random_transaction();
        int         kind;
        int         len;
        logic [3:0] act;
        kind = $urandom_range(99);
        if (kind < 20) begin
            send_word(4'($urandom_range(15)), 1'($urandom_range(1)));
            return;
        end
        send_word(ACT_START, 1'($urandom_range(1)));
        len = $urandom_range(1, 6);
        if (kind < 60) begin
            // The write body mostly has receive-full events, with some discards and
            // stray requests mixed in.
            repeat (len) begin
                case ($urandom_range(9))
                    0: act = ACT_DISCARD_REQ;
                    1: act = ACT_RX_DISCARD;
                    2: act = ACT_READ_REQ;
                    3: act = ACT_READ_RETRY;
                    default: act = ACT_RX_FULL;
                endcase
                send_word(act, 1'($urandom_range(1)));
            end
        end else begin
            // The read body opens with a read request, so the transmit states are reached.
            send_word(ACT_READ_REQ, 1'($urandom_range(1)));
            repeat (len) begin
                case ($urandom_range(11))
                    0, 1, 2, 3: act = ACT_READ_REQ;
                    4:  act = ACT_READ_RETRY;
                    5:  act = ACT_TX_DEPLETED;
                    6:  act = ACT_PAD_NOW;
                    7:  act = ACT_PAD_PREEMPT;
                    8:  act = ACT_TX_TIMEOUT;
                    9:  act = ACT_TX_ABORT;
                    10: act = ACT_RX_FULL;
                    default: act = ACT_DISCARD_REQ;
                endcase
                send_word(act, 1'($urandom_range(1)));
            end
        end
        case ($urandom_range(9))
            0: act = ACT_SHUTDOWN;
            1, 2, 3, 4: act = ACT_RESTART;
            default: act = ACT_STOP;
        endcase
        send_word(act, 1'($urandom_range(1)));
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
        int target;
        target             = words_sent + count;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (words_sent < target) begin
            send_random_transaction();
            // Now and then the sender holds back until the block has drained.
            if ($urandom_range(99) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        evt.valid         = 1'b0;
        evt.action        = '0;
        evt.has_tx_data   = 1'b0;
        rsp.ready         = 1'b0;
        model_state       = ST_IDLE;
        model_depleted_en = 1'b1;
        pin_next          = 1'b0;
        pin_value         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        words_sent        = 0;
        results_checked   = 0;
        error_count       = 0;
        load_directed_table();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The directed walk runs at full rate on both sides.
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].action, directed_rows[i].has_tx_data,
                      directed_rows[i].pinned, directed_rows[i].result);
        end

        // Four random phases. The depleted bit flips between them, so the notification
        // is seen both forwarded and suppressed, though each idling pattern runs with one setting.
        write_depleted_en(1'b0);
        run_random_phase(RANDOM_PER_SET, 0, 0);
        write_depleted_en(1'b1);
        run_random_phase(RANDOM_PER_SET, 74, 0);
        write_depleted_en(1'b0);
        run_random_phase(RANDOM_PER_SET, 0, 74);
        write_depleted_en(1'b1);
        run_random_phase(RANDOM_PER_SET, 28, 28);

        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d event words: a directed walk through all states and codes, then",
                 words_sent);
        $display("random transactions under four idling patterns; %0d results, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
